// ===== sv/wrcd_pkg.sv =====
// ============================================================================
// wrcd_pkg: shared types and constants of the rotation change detector
// Sample and configuration types, register indexes and reset values.
// ============================================================================
package wrcd_pkg;

   // Default number of window entries
   localparam int WINDOW_DEPTH_DEF = 64;

   // Depth of the queue between the front and the back
   localparam int QUEUE_DEPTH = 2;

   // Configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WATCHED_ID   = 2'd0,
      CSR_WINDOW_LEN   = 2'd1,
      CSR_DETECT_EN    = 2'd2,
      CSR_COS_HALF_THR = 2'd3
   } csr_index_type;

   // Register reset values
   localparam logic [15:0] WATCHED_ID_RST   = 16'd0;
   localparam logic [31:0] WINDOW_LEN_RST   = 32'd1000;
   localparam logic        DETECT_EN_RST    = 1'b0;
   localparam logic [15:0] COS_HALF_THR_RST = 16'd32768;

   // Quaternion in Q1.15
   typedef struct packed {
      logic signed [15:0] w;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } quat_type;

   // One watched sample as it travels to the back
   typedef struct packed {
      logic [31:0] timestamp;
      quat_type    rot;
   } sample_type;

   // Configuration registers
   typedef struct packed {
      logic [15:0] watched_id;
      logic [31:0] window_length;
      logic        detect_enable;
      logic [15:0] cos_half_threshold;
   } cfg_type;

endpackage

// ===== sv/wrcd_ifs.sv =====
// ============================================================================
// wrcd channel interfaces
// Valid/ready channels for sample beats in and interval beats out.
// ============================================================================

// Sample channel
interface wrcd_req_if;
   logic               valid;
   logic               ready;
   logic        [15:0] object_id;
   logic        [31:0] timestamp;
   logic signed [15:0] rot_w;
   logic signed [15:0] rot_x;
   logic signed [15:0] rot_y;
   logic signed [15:0] rot_z;

   modport source (
      output valid, object_id, timestamp, rot_w, rot_x, rot_y, rot_z,
      input  ready
   );
   modport sink (
      input  valid, object_id, timestamp, rot_w, rot_x, rot_y, rot_z,
      output ready
   );
endinterface

// Interval channel
interface wrcd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] interval_start;
   logic [31:0] interval_end;
   logic        extends_last;

   modport source (
      output valid, interval_start, interval_end, extends_last,
      input  ready
   );
   modport sink (
      input  valid, interval_start, interval_end, extends_last,
      output ready
   );
endinterface

// ===== sv/wrcd_front.sv =====
// ============================================================================
// wrcd_front: sample intake and classification
// Takes every sample beat, drops those of other objects and queues the
// watched ones for the window engine.
// ============================================================================
module wrcd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic [15:0]         watched_id,
   wrcd_req_if.sink            req_chan,
   output logic                q_valid,
   input  logic                q_ready,
   output wrcd_pkg::sample_type q_sample
);

   localparam int QPTR_W = $clog2(wrcd_pkg::QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(wrcd_pkg::QUEUE_DEPTH + 1);
   localparam logic [QPTR_W-1:0] QLAST = QPTR_W'(wrcd_pkg::QUEUE_DEPTH - 1);

   wrcd_pkg::sample_type queue_mem [wrcd_pkg::QUEUE_DEPTH];

   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              accept;
   logic              push;
   logic              pop;
   wrcd_pkg::sample_type push_sample;

   // Intake: room in the queue means every beat can be taken
   assign req_chan.ready = (cnt_ff != QCNT_W'(wrcd_pkg::QUEUE_DEPTH));
   assign accept         = req_chan.valid && req_chan.ready;
   assign push           = accept && (req_chan.object_id == watched_id);
   assign pop            = q_valid && q_ready;

   assign push_sample.timestamp = req_chan.timestamp;
   assign push_sample.rot.w     = req_chan.rot_w;
   assign push_sample.rot.x     = req_chan.rot_x;
   assign push_sample.rot.y     = req_chan.rot_y;
   assign push_sample.rot.z     = req_chan.rot_z;

   assign q_valid  = (cnt_ff != '0);
   assign q_sample = queue_mem[rd_ptr_ff];

   // Queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QLAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QLAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= push_sample;
      end
   end

endmodule

// ===== sv/wrcd_back.sv =====
// ============================================================================
// wrcd_back: window engine
// Appends each watched sample to the window ring, retires entries that fell
// out of the window, scans the rest with a pipelined dot product and holds
// the interval beat in an output register.
// ============================================================================
module wrcd_back #(
   parameter int WINDOW_DEPTH = wrcd_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  wrcd_pkg::cfg_type    cfg,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  wrcd_pkg::sample_type q_sample,
   wrcd_rsp_if.source           rsp_chan
);

   localparam int IDX_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW_DEPTH);
   localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(WINDOW_DEPTH);

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_PRUNE_RD  = 6'b000010,
      ST_PRUNE_CHK = 6'b000100,
      ST_SCAN      = 6'b001000,
      ST_DRAIN     = 6'b010000,
      ST_EMIT      = 6'b100000
   } state_type;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   // Window memories
   logic [31:0]        times_mem [WINDOW_DEPTH];
   wrcd_pkg::quat_type rot_mem   [WINDOW_DEPTH];

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   oldest_ff, oldest_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   scan_addr_ff, scan_addr_in;
   logic [CNT_W-1:0]   scan_left_ff, scan_left_in;
   logic               hit_ff, hit_in;
   logic               v1_ff, v2_ff, v3_ff, issue;
   logic               have_ff, have_in;
   logic [31:0]        last_end_ff, last_end_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [31:0]        now_ff;
   wrcd_pkg::quat_type rot_ff;
   logic [31:0]        start_ff;
   logic [31:0]        times_rd_ff;
   wrcd_pkg::quat_type rot_rd_ff;
   logic signed [31:0] prod_ff [4];
   logic signed [33:0] sum_ff;
   logic [31:0]        rsp_start_ff, rsp_end_ff;
   logic               rsp_ext_ff;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W:0]     slot_sum;
   logic [IDX_W-1:0]   tail_slot;
   logic [31:0]        age;
   logic [33:0]        dot_mag;
   logic [33:0]        limit;
   logic               load_rsp;
   logic               start_take;
   logic               ext_bit;

   // Free slot after the newest entry, wrapped once
   assign slot_sum  = {1'b0, oldest_ff} + (IDX_W + 1)'(count_ff);
   assign tail_slot = (slot_sum >= DEPTH_X) ? IDX_W'(slot_sum - DEPTH_X)
                                            : IDX_W'(slot_sum);

   assign age     = now_ff - times_rd_ff;
   assign dot_mag = sum_ff[33] ? 34'(-sum_ff) : 34'(sum_ff);
   assign limit   = {3'b000, cfg.cos_half_threshold, 15'd0};
   assign ext_bit = have_ff && (last_end_ff >= start_ff);

   assign q_ready = (state_ff == ST_IDLE);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      oldest_in    = oldest_ff;
      count_in     = count_ff;
      scan_addr_in = scan_addr_ff;
      scan_left_in = scan_left_ff;
      hit_in       = hit_ff || (v3_ff && (dot_mag <= limit));
      have_in      = have_ff;
      last_end_in  = last_end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      wr_en        = 1'b0;
      wr_addr      = tail_slot;
      rd_addr      = oldest_ff;
      issue        = 1'b0;
      load_rsp     = 1'b0;
      start_take   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               wr_en = 1'b1;
               if (count_ff == FULL_CNT) begin
                  wr_addr   = oldest_ff;
                  oldest_in = next_idx(oldest_ff);
               end else begin
                  count_in = count_ff + 1'b1;
               end
               state_in = ST_PRUNE_RD;
            end
         end
         ST_PRUNE_RD: begin
            state_in = ST_PRUNE_CHK;
         end
         ST_PRUNE_CHK: begin
            if ((count_ff > CNT_W'(1)) && (age > cfg.window_length)) begin
               oldest_in = next_idx(oldest_ff);
               count_in  = count_ff - 1'b1;
               state_in  = ST_PRUNE_RD;
            end else begin
               start_take   = 1'b1;
               scan_addr_in = oldest_ff;
               scan_left_in = count_ff - 1'b1;
               hit_in       = 1'b0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_addr = scan_addr_ff;
            if (scan_left_ff != '0) begin
               issue        = 1'b1;
               scan_addr_in = next_idx(scan_addr_ff);
               scan_left_in = scan_left_ff - 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff && !v3_ff) begin
               state_in = (cfg.detect_enable && hit_ff) ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               last_end_in  = now_ff;
               have_in      = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         oldest_ff    <= '0;
         count_ff     <= '0;
         scan_addr_ff <= '0;
         scan_left_ff <= '0;
         hit_ff       <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         have_ff      <= 1'b0;
         last_end_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         scan_addr_ff <= scan_addr_in;
         scan_left_ff <= scan_left_in;
         hit_ff       <= hit_in;
         v1_ff        <= issue;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         have_ff      <= have_in;
         last_end_ff  <= last_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Window memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         times_mem[wr_addr] <= q_sample.timestamp;
         rot_mem[wr_addr]   <= q_sample.rot;
      end
      times_rd_ff <= times_mem[rd_addr];
      rot_rd_ff   <= rot_mem[rd_addr];
   end

   // Current sample and window start
   always_ff @(posedge clock) begin
      if (wr_en) begin
         now_ff <= q_sample.timestamp;
         rot_ff <= q_sample.rot;
      end
      if (start_take) begin
         start_ff <= times_rd_ff;
      end
   end

   // Dot product pipeline: products, then sum
   always_ff @(posedge clock) begin
      prod_ff[0] <= rot_rd_ff.w * rot_ff.w;
      prod_ff[1] <= rot_rd_ff.x * rot_ff.x;
      prod_ff[2] <= rot_rd_ff.y * rot_ff.y;
      prod_ff[3] <= rot_rd_ff.z * rot_ff.z;
      sum_ff     <= 34'(prod_ff[0]) + 34'(prod_ff[1]) +
                    34'(prod_ff[2]) + 34'(prod_ff[3]);
   end

   // Result register
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_start_ff <= start_ff;
         rsp_end_ff   <= now_ff;
         rsp_ext_ff   <= ext_bit;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.interval_start = rsp_start_ff;
   assign rsp_chan.interval_end   = rsp_end_ff;
   assign rsp_chan.extends_last   = rsp_ext_ff;

endmodule

// ===== sv/windowed_rotation_change_detector_unit.sv =====
// ============================================================================
// windowed_rotation_change_detector_unit: top level
// Per sample: append, one window check plus one per retired entry, a scan of
//   each earlier entry, a drain of the dot product pipeline, then an emit on a hit.
// Watched samples are taken one at a time: a new one waits until the last is done,
//   and the scan is paced by the single read port of the window.
// Samples of other objects are taken at one beat per cycle while queue room lasts.
// Reset clears control state and registers; window memories are not cleared.
// ============================================================================
module windowed_rotation_change_detector_unit #(
   parameter int WINDOW_DEPTH = wrcd_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   wrcd_req_if.sink                       req_chan,
   wrcd_rsp_if.source                     rsp_chan,
   input  logic                           csr_we,
   input  logic [wrcd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wrcd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   wrcd_pkg::cfg_type    cfg_ff, cfg_in;
   logic                 q_valid;
   logic                 q_ready;
   wrcd_pkg::sample_type q_sample;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (wrcd_pkg::csr_index_type'(csr_index))
            wrcd_pkg::CSR_WATCHED_ID:   cfg_in.watched_id = csr_wdata[15:0];
            wrcd_pkg::CSR_WINDOW_LEN:   cfg_in.window_length = csr_wdata;
            wrcd_pkg::CSR_DETECT_EN:    cfg_in.detect_enable = csr_wdata[0];
            wrcd_pkg::CSR_COS_HALF_THR: cfg_in.cos_half_threshold = csr_wdata[15:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.watched_id         <= wrcd_pkg::WATCHED_ID_RST;
         cfg_ff.window_length      <= wrcd_pkg::WINDOW_LEN_RST;
         cfg_ff.detect_enable      <= wrcd_pkg::DETECT_EN_RST;
         cfg_ff.cos_half_threshold <= wrcd_pkg::COS_HALF_THR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Intake and classification
   wrcd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .watched_id (cfg_ff.watched_id),
      .req_chan   (req_chan),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_sample   (q_sample)
   );

   // Window engine
   wrcd_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_sample (q_sample),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== tb/sv/tb_windowed_rotation_change_detector_unit.sv =====
// ============================================================================
// tb_windowed_rotation_change_detector_unit: self-checking testbench
// Drives orientation samples into the detector and predicts every interval
// from a local model of the window ring, the age pruning and the |dot| test.
// Short directed runs are followed by randomized phases. Each phase uses its
// own register set, and most phases add random source gaps and sink stalls.
// ============================================================================
module tb_windowed_rotation_change_detector_unit;

   localparam int WIN_DEPTH    = wrcd_pkg::WINDOW_DEPTH_DEF;
   localparam int DRAIN_CYCLES = 1000;
   localparam int CYCLE_LIMIT  = 3000000;
   localparam int PHASE_BEATS  = 163;
   localparam int IVQ_DEPTH    = 256;

   // One sample beat and one interval beat
   typedef struct packed {
      logic [15:0]        object_id;
      logic [31:0]        timestamp;
      wrcd_pkg::quat_type rot;
   } beat_type;

   typedef struct packed {
      logic [31:0] start_time;
      logic [31:0] end_time;
      logic        extends_last;
   } interval_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [wrcd_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [wrcd_pkg::CSR_DATA_W-1:0] csr_wdata;

   wrcd_req_if req_if ();
   wrcd_rsp_if rsp_if ();

   windowed_rotation_change_detector_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Model state: register copy and window ring
   wrcd_pkg::cfg_type  cfg;
   logic [31:0]        win_time [WIN_DEPTH];
   wrcd_pkg::quat_type win_rot  [WIN_DEPTH];
   int                 win_head;
   int                 win_fill;
   logic [31:0]        prev_end;
   bit                 prev_valid;

   // Expected intervals, in order
   interval_type iv_store [IVQ_DEPTH];
   int           iv_wr_cnt;
   int           iv_rd_cnt;
   interval_type got_iv;
   interval_type want_iv;

   bit req_gaps_on;
   bit rsp_stalls_on;
   int error_count;
   int beats_sent;
   int watched_beats;
   int intervals_checked;
   int cycle_count;

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   function automatic longint quat_dot(input wrcd_pkg::quat_type a,
                                       input wrcd_pkg::quat_type b);
      return longint'($signed(a.w)) * longint'($signed(b.w)) +
             longint'($signed(a.x)) * longint'($signed(b.x)) +
             longint'($signed(a.y)) * longint'($signed(b.y)) +
             longint'($signed(a.z)) * longint'($signed(b.z));
   endfunction

   // Append, prune by age, scan earlier entries; queue an interval on a hit when detection is on
   function automatic void predict_interval(input beat_type b);
      logic [31:0]  age;
      longint       limit;
      longint       d;
      bit           hit;
      int           idx;
      interval_type iv;
      if (b.object_id != cfg.watched_id) return;
      watched_beats++;
      if (win_fill >= WIN_DEPTH) begin
         // ring full: overwrite oldest
         win_time[win_head] = b.timestamp;
         win_rot[win_head]  = b.rot;
         win_head = (win_head + 1) % WIN_DEPTH;
      end else begin
         win_time[(win_head + win_fill) % WIN_DEPTH] = b.timestamp;
         win_rot[(win_head + win_fill) % WIN_DEPTH]  = b.rot;
         win_fill++;
      end
      // age is modulo 2^32; newest entry always stays
      age = b.timestamp - win_time[win_head];
      while (win_fill > 1 && age > cfg.window_length) begin
         win_head = (win_head + 1) % WIN_DEPTH;
         win_fill--;
         age = b.timestamp - win_time[win_head];
      end
      limit = longint'(cfg.cos_half_threshold) * 32768;
      hit = 1'b0;
      for (int i = 0; i + 1 < win_fill; i++) begin
         idx = (win_head + i) % WIN_DEPTH;
         d = quat_dot(win_rot[idx], b.rot);
         if (d < 0) d = -d;
         if (d <= limit) hit = 1'b1;
      end
      if (!cfg.detect_enable || !hit) return;
      iv.start_time   = win_time[win_head];
      iv.end_time     = b.timestamp;
      iv.extends_last = prev_valid && (prev_end >= iv.start_time);
      prev_end   = b.timestamp;
      prev_valid = 1'b1;
      iv_store[iv_wr_cnt % IVQ_DEPTH] = iv;
      iv_wr_cnt++;
   endfunction

   // ------------------------------------------------------------------------
   // Interval sink: random stalls and checking
   // ------------------------------------------------------------------------
   initial begin
      int hold;
      int pick;
      rsp_if.ready <= 1'b0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!rsp_stalls_on) begin
            rsp_if.ready <= 1'b1;
         end else if (hold > 0) begin
            rsp_if.ready <= 1'b0;
            hold--;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               rsp_if.ready <= 1'b1;
            end else if (pick < 95) begin
               rsp_if.ready <= 1'b0;
               hold = $urandom_range(0, 3);
            end else begin
               rsp_if.ready <= 1'b0;
               hold = $urandom_range(20, 80);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got_iv.start_time   = rsp_if.interval_start;
         got_iv.end_time     = rsp_if.interval_end;
         got_iv.extends_last = rsp_if.extends_last;
         if (iv_wr_cnt == iv_rd_cnt) begin
            $display("%0t: unexpected interval beat: expected none, got start %h end %h extends %b",
                     $time, got_iv.start_time, got_iv.end_time, got_iv.extends_last);
            error_count++;
         end else begin
            want_iv = iv_store[iv_rd_cnt % IVQ_DEPTH];
            iv_rd_cnt++;
            intervals_checked++;
            if (got_iv.start_time !== want_iv.start_time) begin
               $display("%0t: interval_start mismatch: expected %h, got %h",
                        $time, want_iv.start_time, got_iv.start_time);
               error_count++;
            end
            if (got_iv.end_time !== want_iv.end_time) begin
               $display("%0t: interval_end mismatch: expected %h, got %h",
                        $time, want_iv.end_time, got_iv.end_time);
               error_count++;
            end
            if (got_iv.extends_last !== want_iv.extends_last) begin
               $display("%0t: extends_last mismatch: expected %b, got %b",
                        $time, want_iv.extends_last, got_iv.extends_last);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sample source and register access
   // ------------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      if (!req_gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Valid stays high across back-to-back beats
   task automatic send_beat(input beat_type b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.object_id <= b.object_id;
      req_if.timestamp <= b.timestamp;
      req_if.rot_w     <= b.rot.w;
      req_if.rot_x     <= b.rot.x;
      req_if.rot_y     <= b.rot.y;
      req_if.rot_z     <= b.rot.z;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      beats_sent++;
      predict_interval(b);
   endtask

   task automatic put_sample(input logic [15:0] id, input logic [31:0] ts,
                             input int w, input int x, input int y, input int z);
      beat_type b;
      b.object_id = id;
      b.timestamp = ts;
      b.rot.w = 16'(w);
      b.rot.x = 16'(x);
      b.rot.y = 16'(y);
      b.rot.z = 16'(z);
      send_beat(b);
   endtask

   task automatic csr_put(input wrcd_pkg::csr_index_type idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Writes all four registers; unused upper data bits optionally randomized
   task automatic apply_config(input wrcd_pkg::cfg_type c, input bit upper_noise);
      logic [31:0] noise;
      noise = upper_noise ? 32'($urandom) : 32'd0;
      csr_put(wrcd_pkg::CSR_WATCHED_ID, {noise[31:16], c.watched_id});
      csr_put(wrcd_pkg::CSR_WINDOW_LEN, c.window_length);
      csr_put(wrcd_pkg::CSR_DETECT_EN, {noise[31:1], c.detect_enable});
      csr_put(wrcd_pkg::CSR_COS_HALF_THR, {noise[31:16], c.cos_half_threshold});
      csr_we <= 1'b0;
      cfg = c;
   endtask

   // Wait until all intervals are in, then let in-flight samples finish
   task automatic settle();
      req_if.valid <= 1'b0;
      while (iv_wr_cnt != iv_rd_cnt) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Quaternion generators
   // ------------------------------------------------------------------------
   function automatic wrcd_pkg::quat_type unit_quat();
      real                a [4];
      real                n;
      wrcd_pkg::quat_type q;
      n = 0.0;
      while (n < 0.01) begin
         for (int k = 0; k < 4; k++) a[k] = $urandom_range(0, 65535) / 32767.5 - 1.0;
         n = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3]);
      end
      q.w = 16'($rtoi(a[0] / n * 32767.0));
      q.x = 16'($rtoi(a[1] / n * 32767.0));
      q.y = 16'($rtoi(a[2] / n * 32767.0));
      q.z = 16'($rtoi(a[3] / n * 32767.0));
      return q;
   endfunction

   function automatic logic signed [15:0] nudge(input logic signed [15:0] v);
      int r;
      r = int'(v) + int'($urandom_range(0, 3000)) - 1500;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return 16'(r);
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset register values: detection is off, window is still kept
   task automatic test_reset_config();
      put_sample(16'h0000, 32'd0,  32767, 0, 0, 0);
      put_sample(16'h0000, 32'd10, 0, 32767, 0, 0);
   endtask

   // Id filter, unnormalized and extreme components, threshold extremes
   task automatic test_detect_thresholds();
      wrcd_pkg::cfg_type c;
      settle();
      c = cfg;
      c.detect_enable      = 1'b1;
      c.cos_half_threshold = 16'd23170;
      apply_config(c, 1'b0);
      put_sample(16'hFFFF, 32'd20, 0, 0, 32767, 0);
      put_sample(16'h0000, 32'd20, 0, 0, 0, 32767);
      put_sample(16'h0000, 32'd30, -32768, -32768, -32768, -32768);
      put_sample(16'h0000, 32'd40, 32767, 32767, 32767, 32767);
      // threshold above one: hits readily
      settle();
      c.cos_half_threshold = 16'hFFFF;
      apply_config(c, 1'b0);
      put_sample(16'h0000, 32'd50, 16384, 16384, 16384, 16384);
      // zero threshold: only an exactly orthogonal pair hits
      settle();
      c.cos_half_threshold = 16'd0;
      apply_config(c, 1'b0);
      put_sample(16'h0000, 32'd60, 0, 32767, 0, 0);
   endtask

   // Zero and maximum window length, timestamp wrap, detection off again
   task automatic test_window_edges();
      wrcd_pkg::cfg_type c;
      settle();
      c = cfg;
      c.window_length      = 32'd0;
      c.cos_half_threshold = 16'd32768;
      apply_config(c, 1'b0);
      put_sample(16'h0000, 32'd2000, 32767, 0, 0, 0);
      put_sample(16'h0000, 32'd2000, 0, 0, 32767, 0);
      put_sample(16'h0000, 32'd2001, 0, 32767, 0, 0);
      settle();
      c.window_length = 32'hFFFF_FFFF;
      c.watched_id    = 16'hFFFF;
      apply_config(c, 1'b0);
      put_sample(16'h0000, 32'd2002, 0, 0, 0, 32767);
      put_sample(16'hFFFF, 32'hFFFF_FFF0, 32767, 0, 0, 0);
      put_sample(16'hFFFF, 32'hFFFF_FFFF, -32768, 0, 0, 0);
      put_sample(16'hFFFF, 32'd0, 0, -32768, 0, 0);
      put_sample(16'hFFFF, 32'd5, 0, 0, 0, -32768);
      settle();
      c.detect_enable = 1'b0;
      apply_config(c, 1'b0);
      put_sample(16'hFFFF, 32'd6, 0, 32767, 0, 0);
   endtask

   // Random phases: drifting orientations with jumps, flips and raw noise
   task automatic test_random_windows();
      wrcd_pkg::cfg_type  c;
      beat_type           b;
      wrcd_pkg::quat_type base;
      logic [31:0]        t;
      int                 span;
      int                 r;
      int                 done;
      for (int ph = 0; ph < 8; ph++) begin
         settle();
         c.watched_id    = 16'($urandom);
         c.detect_enable = (ph != 5);
         case (ph)
            0: begin c.window_length = 32'd1000;       c.cos_half_threshold = 16'd30000; end
            1: begin c.window_length = 32'd0;          c.cos_half_threshold = 16'd32768; end
            2: begin c.window_length = 32'hFFFF_FFFF;  c.cos_half_threshold = 16'd31000; end
            3: begin c.window_length = 32'd50;         c.cos_half_threshold = 16'hFFFF;  end
            4: begin c.window_length = 32'd100000;     c.cos_half_threshold = 16'd0;     end
            5: begin c.window_length = 32'd1000;       c.cos_half_threshold = 16'd30000; end
            6: begin c.window_length = 32'd5000;
                     c.cos_half_threshold = 16'($urandom_range(0, 65535)); end
            default: begin c.window_length = 32'hFFFF_FFFF;
                           c.cos_half_threshold = 16'd32200; end
         endcase
         apply_config(c, 1'b1);
         req_gaps_on   = (ph % 4 != 1);
         rsp_stalls_on = (ph % 4 != 2);
         // one phase runs across the timestamp wrap
         t = (ph == 3) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 3000)) : 32'($urandom);
         if (c.window_length == 32'd0)
            span = 1;
         else if (c.window_length == 32'hFFFF_FFFF)
            span = 200;
         else
            span = int'(c.window_length / 24) + 1;
         base = unit_quat();
         done = 0;
         while (done < PHASE_BEATS) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
               // other object: ignored by the block
               b.object_id = cfg.watched_id ^ 16'($urandom_range(1, 65535));
               b.timestamp = 32'($urandom);
               b.rot = 64'({$urandom, $urandom});
               send_beat(b);
               continue;
            end
            // time step: repeat, short step, jump past the window, or backward
            r = $urandom_range(0, 99);
            if (r < 10)
               t = t;
            else if (r < 90)
               t = t + 32'($urandom_range(0, span));
            else if (r < 98)
               t = t + cfg.window_length + 32'($urandom_range(1, 1000));
            else
               t = t - 32'($urandom_range(1, 1000));
            // orientation: drift, new pose, sign flip, or raw components
            r = $urandom_range(0, 99);
            if (r < 65) begin
               base.w = nudge(base.w);
               base.x = nudge(base.x);
               base.y = nudge(base.y);
               base.z = nudge(base.z);
               b.rot = base;
            end else if (r < 80) begin
               base = unit_quat();
               b.rot = base;
            end else if (r < 90) begin
               b.rot.w = -base.w;
               b.rot.x = -base.x;
               b.rot.y = -base.y;
               b.rot.z = -base.z;
            end else begin
               b.rot = 64'({$urandom, $urandom});
            end
            b.object_id = cfg.watched_id;
            b.timestamp = t;
            send_beat(b);
            done++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= wrcd_pkg::CSR_WATCHED_ID;
      csr_wdata        <= '0;
      req_if.valid     <= 1'b0;
      req_if.object_id <= '0;
      req_if.timestamp <= '0;
      req_if.rot_w     <= '0;
      req_if.rot_x     <= '0;
      req_if.rot_y     <= '0;
      req_if.rot_z     <= '0;
      cfg.watched_id         = wrcd_pkg::WATCHED_ID_RST;
      cfg.window_length      = wrcd_pkg::WINDOW_LEN_RST;
      cfg.detect_enable      = wrcd_pkg::DETECT_EN_RST;
      cfg.cos_half_threshold = wrcd_pkg::COS_HALF_THR_RST;
      win_head          = 0;
      win_fill          = 0;
      prev_end          = '0;
      prev_valid        = 1'b0;
      iv_wr_cnt         = 0;
      iv_rd_cnt         = 0;
      req_gaps_on       = 1'b1;
      rsp_stalls_on     = 1'b1;
      error_count       = 0;
      beats_sent        = 0;
      watched_beats     = 0;
      intervals_checked = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_config();
      test_detect_thresholds();
      test_window_edges();
      test_random_windows();
      settle();

      $display("Run covered %0d sample beats (%0d on the watched object) and %0d intervals,",
               beats_sent, watched_beats, intervals_checked);
      $display("across window lengths from zero to maximum and thresholds from zero to full scale.");
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches found", error_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d intervals still pending",
               cycle_count, iv_wr_cnt - iv_rd_cnt);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
sv/wrcd_pkg.sv
sv/wrcd_ifs.sv
sv/wrcd_front.sv
sv/wrcd_back.sv
sv/windowed_rotation_change_detector_unit.sv
tb/sv/tb_windowed_rotation_change_detector_unit.sv
